FILE: hdl/fct_pkg.sv
// shared types and constants of the fat cluster table engine
package fct_pkg;

    localparam int ENTRY_W   = 28;
    localparam int SECTOR_W  = 32;
    localparam int COUNT_W   = 12;
    localparam int SPC_W     = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 64;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPC           = 2'd2;

    localparam logic [ENTRY_W-1:0] EOC_LOW   = 28'h FFFFFF8;
    localparam logic [ENTRY_W-1:0] EOC_MARK  = 28'h FFFFFFF;
    localparam logic [ENTRY_W-1:0] FIRST_CLU = 28'd2;

    // one finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic                valid;
        logic [ENTRY_W-1:0]  entry_value;
        logic [ENTRY_W-1:0]  sec_cluster;  // cluster whose first sector is reported
        logic [STATUS_W-1:0] status;
    } fct_result_t;

endpackage

FILE: hdl/fct_table_ram.sv
// single-port-write, one-read table memory with registered, write-first read data
module fct_table_ram #(
    parameter int ENTRIES = 4096,
    parameter int AW      = 12
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [fct_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [fct_pkg::ENTRY_W-1:0] rdata
);
    import fct_pkg::*;

    logic [ENTRY_W-1:0] mem [ENTRIES];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // a read of the entry being written returns the new value
    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fct_ctrl.sv
// operation sequencer: clearing pass, read, write, allocate scan and chain walk
module fct_ctrl #(
    parameter int ENTRIES = 4096,
    parameter int AW      = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fct_pkg::OP_W-1:0]     in_op,
    input  logic [fct_pkg::ENTRY_W-1:0]  in_cluster,
    input  logic [fct_pkg::ENTRY_W-1:0]  in_new_value,
    input  logic [fct_pkg::COUNT_W-1:0]  cluster_count,
    input  logic                         res_take,
    output fct_pkg::fct_result_t         res,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [fct_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic [AW-1:0]                ram_raddr,
    input  logic [fct_pkg::ENTRY_W-1:0]  ram_rdata
);
    import fct_pkg::*;

    localparam int CW = AW + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_ALLOC = 3'd3;
    localparam logic [2:0] ST_FREE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW-1:0]      cur_reg, cur_next;     // chain entry or scan entry in flight
    logic [CW-1:0]      scan_reg, scan_next;   // next cluster the scan reads
    fct_result_t        res_reg, res_next;

    logic               accept;

    function automatic logic cluster_ok(input logic [ENTRY_W-1:0] c,
                                        input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W:0] lim;
        lim = {1'b0, cnt} + (COUNT_W+1)'(2);
        return (c >= FIRST_CLU) && (c < ENTRY_W'(lim)) &&
               ({1'b0, c} < (ENTRY_W+1)'(ENTRIES));
    endfunction

    function automatic logic ends_chain(input logic [ENTRY_W-1:0] c);
        return (c < FIRST_CLU) || (c >= EOC_LOW);
    endfunction

    assign in_ready = (state_reg == ST_IDLE) && (!res_reg.valid || res_take);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        scan_next  = scan_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = '0;
        ram_raddr  = cur_reg;

        if (res_take) begin
            res_next.valid = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_next.entry_value = '0;
                    res_next.sec_cluster = in_cluster;
                    res_next.status      = STATUS_OK;
                    case (in_op)
                        OP_READ: begin
                            if (cluster_ok(in_cluster, cluster_count)) begin
                                ram_raddr  = in_cluster[AW-1:0];
                                state_next = ST_READ;
                            end else begin
                                res_next.valid  = 1'b1;
                                res_next.status = STATUS_INVALID;
                            end
                        end
                        OP_WRITE: begin
                            res_next.valid = 1'b1;
                            if (cluster_ok(in_cluster, cluster_count)) begin
                                ram_we    = 1'b1;
                                ram_waddr = in_cluster[AW-1:0];
                                ram_wdata = in_new_value;
                            end else begin
                                res_next.status = STATUS_INVALID;
                            end
                        end
                        OP_ALLOC: begin
                            if (cluster_ok(FIRST_CLU, cluster_count)) begin
                                ram_raddr  = AW'(2);
                                cur_next   = AW'(2);
                                scan_next  = CW'(3);
                                state_next = ST_ALLOC;
                            end else begin
                                res_next.valid       = 1'b1;
                                res_next.sec_cluster = '0;
                                res_next.status      = STATUS_NO_FREE;
                            end
                        end
                        OP_FREE: begin
                            if (ends_chain(in_cluster)) begin
                                res_next.valid = 1'b1;
                            end else if (!cluster_ok(in_cluster, cluster_count)) begin
                                res_next.valid  = 1'b1;
                                res_next.status = STATUS_INVALID;
                            end else begin
                                ram_raddr  = in_cluster[AW-1:0];
                                cur_next   = in_cluster[AW-1:0];
                                state_next = ST_FREE;
                            end
                        end
                        default: begin
                            res_next.valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_next.valid       = 1'b1;
                res_next.entry_value = ram_rdata;
                state_next           = ST_IDLE;
            end
            ST_ALLOC: begin
                // one read issued per cycle, the previous one checked
                if (ram_rdata == '0) begin
                    ram_we               = 1'b1;
                    ram_waddr            = cur_reg;
                    ram_wdata            = EOC_MARK;
                    res_next.valid       = 1'b1;
                    res_next.entry_value = ENTRY_W'(cur_reg);
                    res_next.sec_cluster = ENTRY_W'(cur_reg);
                    res_next.status      = STATUS_OK;
                    state_next           = ST_IDLE;
                end else if (cluster_ok(ENTRY_W'(scan_reg), cluster_count)) begin
                    ram_raddr = scan_reg[AW-1:0];
                    cur_next  = scan_reg[AW-1:0];
                    scan_next = scan_reg + CW'(1);
                end else begin
                    res_next.valid       = 1'b1;
                    res_next.entry_value = '0;
                    res_next.sec_cluster = '0;
                    res_next.status      = STATUS_NO_FREE;
                    state_next           = ST_IDLE;
                end
            end
            ST_FREE: begin
                // zero this link and fetch the next one in the same cycle
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = '0;
                if (ends_chain(ram_rdata)) begin
                    res_next.valid  = 1'b1;
                    res_next.status = STATUS_OK;
                    state_next      = ST_IDLE;
                end else if (!cluster_ok(ram_rdata, cluster_count)) begin
                    res_next.valid  = 1'b1;
                    res_next.status = STATUS_INVALID;
                    state_next      = ST_IDLE;
                end else begin
                    ram_raddr = ram_rdata[AW-1:0];
                    cur_next  = ram_rdata[AW-1:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cur_reg   <= '0;
            scan_reg  <= '0;
            res_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cur_reg   <= cur_next;
            scan_reg  <= scan_next;
            res_reg   <= res_next;
        end
    end

    always_comb begin
        res = res_reg;
        // no free cluster reports sector zero
        res.sec_cluster = (res_reg.status == STATUS_NO_FREE) ? '0 : res_reg.sec_cluster;
    end

endmodule

FILE: hdl/fat_cluster_table_engine.sv
// FAT32 cluster table engine: table of 28-bit entries with read, write, allocate
// and free-chain operations. After reset the engine runs a clearing pass over all
// TABLE_ENTRIES entries, one entry a cycle, during which s_tready is low; config
// writes are taken at any time. A write, or an operation that ends at once, is
// done on acceptance; a read waits for the registered table read data; an
// allocate scans entries upward from cluster 2 until one is free or the clusters
// run out; a free walks and zeroes the chain link by link. The single table read
// port, one access a cycle, serves all of these. Results leave through an output
// register, so a new item is taken while the previous result waits on m_tready.
module fat_cluster_table_engine #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] operation, [29:2] cluster, [57:30] new_value, rest zero
    input  logic [fct_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [27:0] entry_value, [59:28] first_sector, [61:60] status, rest zero
    output logic [fct_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fct_pkg::CFG_W-1:0]      cfg_data
);
    import fct_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [COUNT_W-1:0]  cluster_count_reg;
    logic [SECTOR_W-1:0] data_start_reg;
    logic [SPC_W-1:0]    spc_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    fct_result_t         res;
    logic                res_take;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [ENTRY_W-1:0]  sec_offset;
    logic [ENTRY_W+SPC_W-1:0] sec_product;
    logic [SECTOR_W-1:0] first_sector;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_count_reg <= '0;
            data_start_reg    <= '0;
            spc_reg           <= SPC_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CLUSTER_COUNT: cluster_count_reg <= cfg_data[COUNT_W-1:0];
                REG_DATA_START:    data_start_reg    <= cfg_data;
                REG_SPC:           spc_reg           <= cfg_data[SPC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fct_table_ram #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fct_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tdata[OP_W-1:0]),
        .in_cluster    (s_tdata[OP_W +: ENTRY_W]),
        .in_new_value  (s_tdata[OP_W+ENTRY_W +: ENTRY_W]),
        .cluster_count (cluster_count_reg),
        .res_take      (res_take),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    // sector = data_start + (c - 2) * cluster size in sectors, mod 2^32
    assign sec_offset  = res.sec_cluster - FIRST_CLU;
    assign sec_product = {{SPC_W{1'b0}}, sec_offset} * {{ENTRY_W{1'b0}}, spc_reg};
    assign first_sector = (res.sec_cluster < FIRST_CLU) ? '0 :
                          data_start_reg + sec_product[SECTOR_W-1:0];

    assign res_take = res.valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= {{(M_DATA_W-ENTRY_W-SECTOR_W-STATUS_W){1'b0}},
                            res.status, first_sector, res.entry_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
